// ----- hdl/amd_pkg.sv -----
// Shared widths, constants and word types for the affine matrix decompose unit.
`default_nettype none
package amd_pkg;
    localparam int DATA_W      = 32;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = 32;
    localparam int QBITS       = 30;
    localparam int QUO_W       = QBITS + 1;
    localparam int SCALE_W     = 31;
    localparam int QUEUE_DEPTH = 4;

    // Word written by the front into the queue
    typedef struct packed {
        logic [2:0][2:0][DATA_W-1:0] mag;
        logic [2:0][2:0]             sgn;
        logic [2:0][2:0][SQ_W-1:0]   sq;
        logic [2:0][DATA_W-1:0]      trans;
    } mat_word_t;

    // Carried alongside the column length roots
    typedef struct packed {
        logic [2:0][2:0][DATA_W-1:0] mag;
        logic [2:0][2:0]             sgn;
        logic [2:0][DATA_W-1:0]      trans;
    } col_side_t;

    // Carried alongside the normalizing divides
    typedef struct packed {
        logic [2:0][2:0]             sgn;
        logic [2:0][SCALE_W-1:0]     scale;
        logic                        degen;
        logic [2:0][DATA_W-1:0]      trans;
    } rot_side_t;

    // Carried alongside the quaternion length root
    typedef struct packed {
        logic [3:0][DATA_W-1:0]      vmag;
        logic [3:0]                  sgn;
        logic [2:0][SCALE_W-1:0]     scale;
        logic                        degen;
        logic [2:0][DATA_W-1:0]      trans;
    } qlen_side_t;

    // Carried alongside the quaternion divides
    typedef struct packed {
        logic [3:0]                  sgn;
        logic [2:0][SCALE_W-1:0]     scale;
        logic                        degen;
        logic [2:0][DATA_W-1:0]      trans;
    } quat_side_t;
endpackage
`default_nettype wire

// ----- hdl/amd_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit per stage, several lanes in lockstep.
`default_nettype none
module amd_sqrt_pipe #(
    parameter int LANES  = 3,
    parameter int ROOT_W = amd_pkg::ROOT_W,
    parameter int SIDE_W = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_valid,
    input  wire logic [2*ROOT_W-1:0]   in_rad [LANES],
    input  wire logic [SIDE_W-1:0]     in_side,
    output logic                       out_valid,
    output logic [ROOT_W-1:0]          out_root [LANES],
    output logic [SIDE_W-1:0]          out_side
);
    localparam int IN_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              valid_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];
    logic [IN_W-1:0]   rad_reg   [ROOT_W][LANES];
    logic [REM_W-1:0]  rem_reg   [ROOT_W][LANES];
    logic [ROOT_W-1:0] root_reg  [ROOT_W][LANES];

    genvar s, l;
    for (s = 0; s < ROOT_W; s++)
    begin : g_stage
        logic              v_src;
        logic [SIDE_W-1:0] side_src;

        if (s == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign v_src    = valid_reg[s-1];
            assign side_src = side_reg[s-1];
        end

        // advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (adv)
                valid_reg[s] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[s] <= side_src;
        end

        for (l = 0; l < LANES; l++)
        begin : g_lane
            logic [IN_W-1:0]   rad_src;
            logic [REM_W-1:0]  rem_src;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic [ROOT_W-1:0] root_src;
            logic              ge;

            if (s == 0)
            begin : g_first
                assign rad_src  = in_rad[l];
                assign rem_src  = '0;
                assign root_src = '0;
            end
            else
            begin : g_next
                assign rad_src  = rad_reg[s-1][l];
                assign rem_src  = rem_reg[s-1][l];
                assign root_src = root_reg[s-1][l];
            end

            // bring down two radicand bits and try the next root bit
            assign rem_sh = {rem_src[REM_W-3:0], rad_src[IN_W-1 -: 2]};
            assign trial  = {1'b0, root_src, 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rad_reg[s][l]  <= {rad_src[IN_W-3:0], 2'b00};
                    rem_reg[s][l]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[s][l] <= {root_src[ROOT_W-2:0], ge};
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    for (l = 0; l < LANES; l++)
    begin : g_out
        assign out_root[l] = root_reg[ROOT_W-1][l];
    end
endmodule
`default_nettype wire

// ----- hdl/amd_div_pipe.sv -----
// Pipelined fractional divider: trunc(num * 2^(QUO_W-1) / den) for num <= den, one bit a stage.
`default_nettype none
module amd_div_pipe #(
    parameter int LANES  = 9,
    parameter int DIV_W  = amd_pkg::DATA_W,
    parameter int QUO_W  = amd_pkg::QUO_W,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [DIV_W-1:0]  in_num [LANES],
    input  wire logic [DIV_W-1:0]  in_den [LANES],
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       out_quo [LANES],
    output logic [SIDE_W-1:0]      out_side
);
    logic              valid_reg [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];
    logic [DIV_W-1:0]  rem_reg   [QUO_W][LANES];
    logic [DIV_W-1:0]  den_reg   [QUO_W][LANES];
    logic [QUO_W-1:0]  quo_reg   [QUO_W][LANES];

    genvar s, l;
    for (s = 0; s < QUO_W; s++)
    begin : g_stage
        logic              v_src;
        logic [SIDE_W-1:0] side_src;

        if (s == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign v_src    = valid_reg[s-1];
            assign side_src = side_reg[s-1];
        end

        // advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (adv)
                valid_reg[s] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[s] <= side_src;
        end

        for (l = 0; l < LANES; l++)
        begin : g_lane
            logic [DIV_W:0]   sh;
            logic [DIV_W:0]   diff;
            logic [DIV_W-1:0] den_src;
            logic [QUO_W-1:0] quo_src;
            logic             ge;

            if (s == 0)
            begin : g_first
                assign sh      = {1'b0, in_num[l]};
                assign den_src = in_den[l];
                assign quo_src = '0;
            end
            else
            begin : g_next
                assign sh      = {rem_reg[s-1][l], 1'b0};
                assign den_src = den_reg[s-1][l];
                assign quo_src = quo_reg[s-1][l];
            end

            // compare and subtract for one quotient bit
            assign diff = sh - {1'b0, den_src};
            assign ge   = (sh >= {1'b0, den_src});

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s][l] <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
                    den_reg[s][l] <= den_src;
                    quo_reg[s][l] <= {quo_src[QUO_W-2:0], ge};
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];
    for (l = 0; l < LANES; l++)
    begin : g_out
        assign out_quo[l] = quo_reg[QUO_W-1][l];
    end
endmodule
`default_nettype wire

// ----- hdl/amd_front.sv -----
// Front: accepts matrix words, splits elements into sign and magnitude, squares them.
`default_nettype none
module amd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 mat_valid,
    output logic                      mat_stall,
    input  wire logic signed [31:0]   m_c0_r0,
    input  wire logic signed [31:0]   m_c0_r1,
    input  wire logic signed [31:0]   m_c0_r2,
    input  wire logic signed [31:0]   m_c1_r0,
    input  wire logic signed [31:0]   m_c1_r1,
    input  wire logic signed [31:0]   m_c1_r2,
    input  wire logic signed [31:0]   m_c2_r0,
    input  wire logic signed [31:0]   m_c2_r1,
    input  wire logic signed [31:0]   m_c2_r2,
    input  wire logic signed [31:0]   m_c3_r0,
    input  wire logic signed [31:0]   m_c3_r1,
    input  wire logic signed [31:0]   m_c3_r2,
    input  wire logic                 q_full,
    output logic                      wr_valid,
    output amd_pkg::mat_word_t        wr_word
);
    logic                                      front_valid_reg;
    logic                                      front_valid_next;
    logic [2:0][2:0][amd_pkg::DATA_W-1:0]      el_reg;
    logic [2:0][amd_pkg::DATA_W-1:0]           trans_reg;
    logic                                      accept;

    assign mat_stall = front_valid_reg && q_full;
    assign accept    = mat_valid && !mat_stall;
    assign wr_valid  = front_valid_reg;

    // hold the word until the queue takes it
    always_comb
    begin
        if (accept)
            front_valid_next = 1'b1;
        else if (front_valid_reg && !q_full)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            el_reg[0][0] <= m_c0_r0;
            el_reg[0][1] <= m_c0_r1;
            el_reg[0][2] <= m_c0_r2;
            el_reg[1][0] <= m_c1_r0;
            el_reg[1][1] <= m_c1_r1;
            el_reg[1][2] <= m_c1_r2;
            el_reg[2][0] <= m_c2_r0;
            el_reg[2][1] <= m_c2_r1;
            el_reg[2][2] <= m_c2_r2;
            trans_reg[0] <= m_c3_r0;
            trans_reg[1] <= m_c3_r1;
            trans_reg[2] <= m_c3_r2;
        end
    end

    // split sign and magnitude, square each element
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                wr_word.sgn[c][r] = el_reg[c][r][amd_pkg::DATA_W-1];
                wr_word.mag[c][r] = el_reg[c][r][amd_pkg::DATA_W-1]
                                    ? (~el_reg[c][r] + 1'b1) : el_reg[c][r];
                wr_word.sq[c][r]  = amd_pkg::SQ_W'(wr_word.mag[c][r])
                                    * amd_pkg::SQ_W'(wr_word.mag[c][r]);
            end
        end
        wr_word.trans = trans_reg;
    end
endmodule
`default_nettype wire

// ----- hdl/amd_queue.sv -----
// Short queue of classified matrix words between the front and the back.
`default_nettype none
module amd_queue #(
    parameter int DEPTH = amd_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    input  wire amd_pkg::mat_word_t  wr_word,
    output logic                     full,
    input  wire logic                rd_en,
    output logic                     rd_valid,
    output amd_pkg::mat_word_t       rd_word
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    amd_pkg::mat_word_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_word  = mem[rd_ptr_reg];
    assign push     = wr_valid && !full;
    assign pop      = rd_en && rd_valid;

    // advance pointers with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_word;
    end
endmodule
`default_nettype wire

// ----- hdl/amd_back.sv -----
// Back: column lengths, normalization, trace-method quaternion, unit scaling, result register.
`default_nettype none
module amd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 hd_valid,
    input  wire amd_pkg::mat_word_t   hd_word,
    output logic                      hd_pop,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output logic [30:0]               scale_x,
    output logic [30:0]               scale_y,
    output logic [30:0]               scale_z,
    output logic signed [31:0]        quat_x,
    output logic signed [31:0]        quat_y,
    output logic signed [31:0]        quat_z,
    output logic signed [31:0]        quat_w,
    output logic signed [31:0]        trans_x,
    output logic signed [31:0]        trans_y,
    output logic signed [31:0]        trans_z,
    output logic                      degenerate
);
    localparam int DW    = amd_pkg::DATA_W;
    localparam int SW    = amd_pkg::SQ_W;
    localparam int QW    = amd_pkg::QUO_W;
    localparam int SCW   = amd_pkg::SCALE_W;
    localparam int VW    = 35;
    localparam logic signed [VW-1:0] ONE_Q = VW'(64'sd1 <<< amd_pkg::QBITS);
    localparam logic [DW-1:0]        IDENT_W = DW'(64'd1 << amd_pkg::QBITS);

    logic adv;

    logic                    res_valid_reg;
    logic [2:0][SCW-1:0]     scale_reg;
    logic [3:0][DW-1:0]      quat_reg;
    logic [2:0][DW-1:0]      trans_reg;
    logic                    degen_reg;

    // whole back advances unless a finished word is held
    assign adv    = !res_valid_reg || !res_stall;
    assign hd_pop = adv && hd_valid;

    // column lengths
    logic [SW-1:0]           col_ss  [3];
    logic [DW-1:0]           col_len [3];
    amd_pkg::col_side_t      col_side_in, col_side_out;
    logic                    len_valid;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            col_ss[c] = hd_word.sq[c][0] + hd_word.sq[c][1] + hd_word.sq[c][2];
        col_side_in.mag   = hd_word.mag;
        col_side_in.sgn   = hd_word.sgn;
        col_side_in.trans = hd_word.trans;
    end

    amd_sqrt_pipe #(
        .LANES  (3),
        .ROOT_W (amd_pkg::ROOT_W),
        .SIDE_W ($bits(amd_pkg::col_side_t))
    ) u_col_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (hd_valid),
        .in_rad    (col_ss),
        .in_side   (col_side_in),
        .out_valid (len_valid),
        .out_root  (col_len),
        .out_side  (col_side_out)
    );

    // normalize each element by its column length
    logic [DW-1:0]           nrm_num [9];
    logic [DW-1:0]           nrm_den [9];
    logic [QW-1:0]           nrm_quo [9];
    amd_pkg::rot_side_t      rot_side_in, rot_side_out;
    logic                    nrm_valid;

    always_comb
    begin
        rot_side_in.degen = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            rot_side_in.scale[c] = col_len[c][DW-1] ? {SCW{1'b1}} : col_len[c][SCW-1:0];
            if (col_len[c] == '0)
                rot_side_in.degen = 1'b1;
            for (int r = 0; r < 3; r++)
            begin
                nrm_num[c*3+r] = col_side_out.mag[c][r];
                nrm_den[c*3+r] = col_len[c];
            end
        end
        rot_side_in.sgn   = col_side_out.sgn;
        rot_side_in.trans = col_side_out.trans;
    end

    amd_div_pipe #(
        .LANES  (9),
        .DIV_W  (DW),
        .QUO_W  (QW),
        .SIDE_W ($bits(amd_pkg::rot_side_t))
    ) u_nrm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (len_valid),
        .in_num    (nrm_num),
        .in_den    (nrm_den),
        .in_side   (rot_side_in),
        .out_valid (nrm_valid),
        .out_quo   (nrm_quo),
        .out_side  (rot_side_out)
    );

    // trace method: pick the branch and form the unscaled quaternion
    logic signed [VW-1:0]    nn [3][3];
    logic signed [VW-1:0]    trace, arg, argc;
    logic signed [VW-1:0]    vv [4];
    logic signed [VW-1:0]    vq [4];

    // divide by four, rounding toward zero
    function automatic logic signed [VW-1:0] quarter(input logic signed [VW-1:0] x);
        logic signed [VW-1:0] q;
        q = x >>> 2;
        if (x[VW-1] && (x[1:0] != 2'b00))
            q = q + VW'(1);
        return q;
    endfunction

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                nn[r][c] = rot_side_out.sgn[c][r]
                           ? -$signed({4'b0000, nrm_quo[c*3+r]})
                           :  $signed({4'b0000, nrm_quo[c*3+r]});
        trace = nn[0][0] + nn[1][1] + nn[2][2];
        priority if (trace > 0)
        begin
            arg   = trace + ONE_Q;
            argc  = arg;
            vv[3] = arg;
            vv[0] = nn[2][1] - nn[1][2];
            vv[1] = nn[0][2] - nn[2][0];
            vv[2] = nn[1][0] - nn[0][1];
        end
        else if (nn[0][0] > nn[1][1] && nn[0][0] > nn[2][2])
        begin
            arg   = ONE_Q + nn[0][0] - nn[1][1] - nn[2][2];
            argc  = arg[VW-1] ? '0 : arg;
            vv[3] = nn[2][1] - nn[1][2];
            vv[0] = argc;
            vv[1] = nn[0][1] + nn[1][0];
            vv[2] = nn[0][2] + nn[2][0];
        end
        else if (nn[1][1] > nn[2][2])
        begin
            arg   = ONE_Q + nn[1][1] - nn[0][0] - nn[2][2];
            argc  = arg[VW-1] ? '0 : arg;
            vv[3] = nn[0][2] - nn[2][0];
            vv[0] = nn[0][1] + nn[1][0];
            vv[1] = argc;
            vv[2] = nn[1][2] + nn[2][1];
        end
        else
        begin
            arg   = ONE_Q + nn[2][2] - nn[0][0] - nn[1][1];
            argc  = arg[VW-1] ? '0 : arg;
            vv[3] = nn[1][0] - nn[0][1];
            vv[0] = nn[0][2] + nn[2][0];
            vv[1] = nn[1][2] + nn[2][1];
            vv[2] = argc;
        end
        for (int i = 0; i < 4; i++)
            vq[i] = quarter(vv[i]);
    end

    logic                    q_valid_reg;
    logic signed [VW-1:0]    vq_reg [4];
    amd_pkg::rot_side_t      q_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (adv)
            q_valid_reg <= nrm_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                vq_reg[i] <= vq[i];
            q_side_reg <= rot_side_out;
        end
    end

    // square the components
    logic [VW-1:0]           vabs [4];
    logic [DW-1:0]           vmag [4];
    logic                    m_valid_reg;
    logic [3:0][DW-1:0]      m_vmag_reg;
    logic [3:0]              m_vsgn_reg;
    logic [SW-1:0]           m_vsq_reg [4];
    amd_pkg::rot_side_t      m_side_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            vabs[i] = vq_reg[i][VW-1] ? VW'(-vq_reg[i]) : VW'(vq_reg[i]);
            vmag[i] = vabs[i][DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= q_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                m_vmag_reg[i] <= vmag[i];
                m_vsgn_reg[i] <= vq_reg[i][VW-1];
                m_vsq_reg[i]  <= SW'(vmag[i]) * SW'(vmag[i]);
            end
            m_side_reg <= q_side_reg;
        end
    end

    // quaternion length
    logic [SW-1:0]           ql_ss [1];
    logic [DW-1:0]           ql_root [1];
    amd_pkg::qlen_side_t     ql_side_in, ql_side_out;
    logic                    ql_valid;

    always_comb
    begin
        ql_ss[0]         = m_vsq_reg[0] + m_vsq_reg[1] + m_vsq_reg[2] + m_vsq_reg[3];
        ql_side_in.vmag  = m_vmag_reg;
        ql_side_in.sgn   = m_vsgn_reg;
        ql_side_in.scale = m_side_reg.scale;
        ql_side_in.degen = m_side_reg.degen;
        ql_side_in.trans = m_side_reg.trans;
    end

    amd_sqrt_pipe #(
        .LANES  (1),
        .ROOT_W (amd_pkg::ROOT_W),
        .SIDE_W ($bits(amd_pkg::qlen_side_t))
    ) u_quat_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (m_valid_reg),
        .in_rad    (ql_ss),
        .in_side   (ql_side_in),
        .out_valid (ql_valid),
        .out_root  (ql_root),
        .out_side  (ql_side_out)
    );

    // scale the quaternion to unit length
    logic [DW-1:0]           un_num [4];
    logic [DW-1:0]           un_den [4];
    logic [QW-1:0]           un_quo [4];
    amd_pkg::quat_side_t     un_side_in, un_side_out;
    logic                    un_valid;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            un_num[i] = ql_side_out.vmag[i];
            un_den[i] = ql_root[0];
        end
        un_side_in.sgn   = ql_side_out.sgn;
        un_side_in.scale = ql_side_out.scale;
        un_side_in.degen = ql_side_out.degen || (ql_root[0] == '0);
        un_side_in.trans = ql_side_out.trans;
    end

    amd_div_pipe #(
        .LANES  (4),
        .DIV_W  (DW),
        .QUO_W  (QW),
        .SIDE_W ($bits(amd_pkg::quat_side_t))
    ) u_unit_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ql_valid),
        .in_num    (un_num),
        .in_den    (un_den),
        .in_side   (un_side_in),
        .out_valid (un_valid),
        .out_quo   (un_quo),
        .out_side  (un_side_out)
    );

    // apply signs, force identity on a degenerate matrix
    logic [3:0][DW-1:0]      quat_fin;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (un_side_out.degen)
                quat_fin[i] = (i == 3) ? IDENT_W : '0;
            else if (un_side_out.sgn[i])
                quat_fin[i] = -{1'b0, un_quo[i]};
            else
                quat_fin[i] = {1'b0, un_quo[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= un_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && un_valid)
        begin
            scale_reg <= un_side_out.scale;
            quat_reg  <= quat_fin;
            trans_reg <= un_side_out.trans;
            degen_reg <= un_side_out.degen;
        end
    end

    assign res_valid  = res_valid_reg;
    assign scale_x    = scale_reg[0];
    assign scale_y    = scale_reg[1];
    assign scale_z    = scale_reg[2];
    assign quat_x     = $signed(quat_reg[0]);
    assign quat_y     = $signed(quat_reg[1]);
    assign quat_z     = $signed(quat_reg[2]);
    assign quat_w     = $signed(quat_reg[3]);
    assign trans_x    = $signed(trans_reg[0]);
    assign trans_y    = $signed(trans_reg[1]);
    assign trans_z    = $signed(trans_reg[2]);
    assign degenerate = degen_reg;
endmodule
`default_nettype wire

// ----- hdl/affine_matrix_decompose_unit.sv -----
// Top level of the affine matrix decompose unit: front, queue, back and checks.
//
// Input channel mat_valid/mat_stall takes one 3x4 affine matrix per word (Q16.16
// elements, column-major, fourth column is translation). Output channel
// res_valid/res_stall delivers per-column scale, a unit Q2.30 quaternion, the
// translation and a degenerate flag, one word per input word, in order.
// Throughput: one word per cycle while the back is not frozen by res_stall,
// with no dependency between words. Between the accepting edge and the edge
// that raises res_valid a word is registered in the front register, the queue,
// the two 32-stage square root pipes and the two 31-stage divide pipes in the
// back, two quaternion stages and the output register.
// A stall on the result side freezes the back; the front keeps accepting into
// the 4-word queue and raises mat_stall only once the queue and the front
// register are both full.
// Reset clears all valid bits, queue pointers and the result flag; no word is
// in flight afterward. A zero column or a zero quaternion length yields the
// identity quaternion with degenerate set.
`default_nettype none
module affine_matrix_decompose_unit #(
    parameter int QUEUE_DEPTH = amd_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                mat_valid,
    output logic                     mat_stall,
    input  wire logic signed [31:0]  m_c0_r0,
    input  wire logic signed [31:0]  m_c0_r1,
    input  wire logic signed [31:0]  m_c0_r2,
    input  wire logic signed [31:0]  m_c1_r0,
    input  wire logic signed [31:0]  m_c1_r1,
    input  wire logic signed [31:0]  m_c1_r2,
    input  wire logic signed [31:0]  m_c2_r0,
    input  wire logic signed [31:0]  m_c2_r1,
    input  wire logic signed [31:0]  m_c2_r2,
    input  wire logic signed [31:0]  m_c3_r0,
    input  wire logic signed [31:0]  m_c3_r1,
    input  wire logic signed [31:0]  m_c3_r2,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [30:0]              scale_x,
    output logic [30:0]              scale_y,
    output logic [30:0]              scale_z,
    output logic signed [31:0]       quat_x,
    output logic signed [31:0]       quat_y,
    output logic signed [31:0]       quat_z,
    output logic signed [31:0]       quat_w,
    output logic signed [31:0]       trans_x,
    output logic signed [31:0]       trans_y,
    output logic signed [31:0]       trans_z,
    output logic                     degenerate
);
    logic                q_full;
    logic                wr_valid;
    amd_pkg::mat_word_t  wr_word;
    logic                hd_valid;
    logic                hd_pop;
    amd_pkg::mat_word_t  hd_word;

    amd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .m_c0_r0   (m_c0_r0),
        .m_c0_r1   (m_c0_r1),
        .m_c0_r2   (m_c0_r2),
        .m_c1_r0   (m_c1_r0),
        .m_c1_r1   (m_c1_r1),
        .m_c1_r2   (m_c1_r2),
        .m_c2_r0   (m_c2_r0),
        .m_c2_r1   (m_c2_r1),
        .m_c2_r2   (m_c2_r2),
        .m_c3_r0   (m_c3_r0),
        .m_c3_r1   (m_c3_r1),
        .m_c3_r2   (m_c3_r2),
        .q_full    (q_full),
        .wr_valid  (wr_valid),
        .wr_word   (wr_word)
    );

    amd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_word  (wr_word),
        .full     (q_full),
        .rd_en    (hd_pop),
        .rd_valid (hd_valid),
        .rd_word  (hd_word)
    );

    amd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .hd_valid   (hd_valid),
        .hd_word    (hd_word),
        .hd_pop     (hd_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .scale_x    (scale_x),
        .scale_y    (scale_y),
        .scale_z    (scale_z),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .trans_x    (trans_x),
        .trans_y    (trans_y),
        .trans_z    (trans_z),
        .degenerate (degenerate)
    );

    // input stalls only while the front holds a word the queue cannot take
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> (wr_valid && q_full))
        else $error("input stalled without a blocked front word");

    // the back never pops an empty queue
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        hd_pop |-> hd_valid)
        else $error("queue popped while empty");

    // a degenerate result carries the identity quaternion
    a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && degenerate) |->
            (quat_x == 32'sd0 && quat_y == 32'sd0 && quat_z == 32'sd0
             && quat_w == 32'sh40000000))
        else $error("degenerate result without identity quaternion");
endmodule
`default_nettype wire
